/* rtl/core/point_in_polygon_test_defines.svh */
// assertion macros for the point-in-polygon test block
// needs a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ppt_pkg.sv */
// shared constants and types for the point-in-polygon test block
// no dependencies
package ppt_pkg;

    localparam int PPT_MAX_VERTICES = 64;
    localparam int PPT_COORD_WIDTH  = 16;
    localparam int INDEX_WIDTH      = 6;
    localparam int COUNT_WIDTH      = 7;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    // control that travels with each vertex read into the edge unit
    typedef struct packed {
        logic clear;   // new test, drop the old parity
        logic valid;   // vertex data on the memory output this cycle
        logic prime;   // this vertex only seeds the previous-vertex register
        logic last;    // final edge of the walk
    } t_edge_ctl;

    typedef struct packed {
        logic done;    // final edge is in the compare stage, not yet in the parity
        logic parity;  // running crossing parity
    } t_edge_stat;

endpackage

/* rtl/core/ppt_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ppt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ppt_edge.sv */
// edge crossing datapath: differences, cross products, compare, parity
// depends on ppt_pkg for the control and status structs
module ppt_edge #(
    parameter int COORD_WIDTH = ppt_pkg::PPT_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppt_pkg::t_edge_ctl            i_ctl,
    input  logic signed [COORD_WIDTH-1:0] i_vx,
    input  logic signed [COORD_WIDTH-1:0] i_vy,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    output ppt_pkg::t_edge_stat           o_stat
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    // previous vertex (j of the edge)
    logic signed [COORD_WIDTH-1:0] r_jx, r_jy;

    // stage 1: differences
    logic                 r1_vld, r1_last, r1_cross, r1_dypos;
    logic signed [DW-1:0] r1_dxp, r1_dy, r1_dxe, r1_dyp;
    logic signed [DW-1:0] n1_dy;
    logic                 n1_cross;

    // stage 2: products
    logic                 r2_vld, r2_last, r2_cross, r2_dypos;
    logic signed [PW-1:0] r2_p1, r2_p2;

    logic r_parity;
    logic w_left;

    always_comb begin
        n1_dy    = DW'(r_jy) - DW'(i_vy);
        n1_cross = (i_vy > i_py) != (r_jy > i_py);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_jx <= i_vx;
            r_jy <= i_vy;
        end
        r1_dxp   <= DW'(i_px) - DW'(i_vx);
        r1_dy    <= n1_dy;
        r1_dxe   <= DW'(r_jx) - DW'(i_vx);
        r1_dyp   <= DW'(i_py) - DW'(i_vy);
        r1_cross <= n1_cross;
        r1_dypos <= n1_dy > 0;
        r1_last  <= i_ctl.last;

        r2_p1    <= PW'(r1_dxp) * PW'(r1_dy);
        r2_p2    <= PW'(r1_dxe) * PW'(r1_dyp);
        r2_cross <= r1_cross;
        r2_dypos <= r1_dypos;
        r2_last  <= r1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= i_ctl.valid && !i_ctl.prime;
            r2_vld <= r1_vld;
        end
    end

    // sign of the y span decides which way the cross-multiplied compare goes
    assign w_left = r2_dypos ? (r2_p1 < r2_p2) : (r2_p2 < r2_p1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
        end else if (i_ctl.clear) begin
            r_parity <= 1'b0;
        end else if (r2_vld && r2_cross && w_left) begin
            r_parity <= !r_parity;
        end
    end

    assign o_stat.done   = r2_vld && r2_last;
    assign o_stat.parity = r_parity;

endmodule

/* rtl/core/point_in_polygon_test.sv */
// top level of the point-in-polygon geofence test
// depends on ppt_pkg, ppt_ram, ppt_edge and point_in_polygon_test_defines.svh
//
// Crossing-number (ray casting) geofence. A write beat (command 0) stores one
// polygon vertex at vertex_index; writes to a slot at or beyond MAX_VERTICES
// are dropped. A test beat (command 1) checks the point against the first
// vertex_count vertices (capped at MAX_VERTICES) and gives one result beat,
// inside_res, which is the parity of edge crossings. The left-of-edge
// decision is exact: both cross products are formed at full width and
// compared, with the sign of the edge's y span picking the direction.
// Vertices sit in one ram (x and y side by side) with one read port, so a
// test walks the polygon one vertex per cycle: n+1 reads (the last vertex
// first, to seed the wrapping edge), three pipeline stages, then the finish
// state loads the result. A vertex count of zero goes straight to the finish
// state and answers outside. One beat is worked on at a time; a write may be
// accepted while an earlier result still waits in the output register, and a
// test that finishes then holds until that result is taken. Reading a vertex
// slot that was never written gives an undefined answer. vertex_count is
// written through i_cfg_we / i_cfg_wdata; the user must write it only while
// the block is idle, as the block itself does not enforce this.
`include "point_in_polygon_test_defines.svh"

module point_in_polygon_test #(
    parameter int MAX_VERTICES = ppt_pkg::PPT_MAX_VERTICES,
    parameter int COORD_WIDTH  = ppt_pkg::PPT_COORD_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [ppt_pkg::COUNT_WIDTH-1:0]     i_cfg_wdata,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic [ppt_pkg::INDEX_WIDTH-1:0]     i_vertex_index,
    input  logic signed [COORD_WIDTH-1:0]       i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]       i_coord_y,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_inside_res
);

    localparam int          AW   = $clog2(MAX_VERTICES);
    localparam int          NW   = AW + 1;               // holds 0..MAX_VERTICES
    localparam int          RW   = 2 * COORD_WIDTH;
    localparam logic [31:0] MAXV = 32'(MAX_VERTICES);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_WAIT   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] r_state, n_state;

    logic [ppt_pkg::COUNT_WIDTH-1:0] r_vcount;

    // test point and walk bookkeeping
    logic signed [COORD_WIDTH-1:0] r_px, r_py;
    logic [NW-1:0]                 r_n, n_n;
    logic [NW-1:0]                 r_cnt, n_cnt;

    // read control, registered to line up with the ram output
    logic r_rd_vld, r_rd_prime, r_rd_last;

    logic r_out_valid, n_out_valid;
    logic r_out_inside, n_out_inside;

    logic w_accept, w_test, w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [RW-1:0] w_rdata;
    logic [NW-1:0] w_n_eff;
    logic w_out_free;

    ppt_pkg::t_edge_ctl  w_ctl;
    ppt_pkg::t_edge_stat w_stat;

    // input handshake: one beat at a time, only from idle
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_test   = w_accept && (i_command == ppt_pkg::CMD_TEST);
    assign w_we     = w_accept && (i_command == ppt_pkg::CMD_WRITE)
                      && (32'(i_vertex_index) < MAXV);
    assign w_waddr  = AW'(i_vertex_index);

    // vertex count saturates at the store's capacity
    assign w_n_eff  = (32'(r_vcount) > MAXV) ? NW'(MAX_VERTICES) : NW'(r_vcount);

    // first read seeds the wrapping edge with the last vertex
    assign w_raddr  = (r_cnt == '0) ? AW'(r_n - NW'(1)) : AW'(r_cnt - NW'(1));

    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        w_ctl.clear = w_test;
        w_ctl.valid = r_rd_vld;
        w_ctl.prime = r_rd_prime;
        w_ctl.last  = r_rd_last;
    end

    ppt_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_coord_x, i_coord_y}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ppt_edge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_vx    (w_rdata[RW-1:COORD_WIDTH]),
        .i_vy    (w_rdata[COORD_WIDTH-1:0]),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_stat  (w_stat)
    );

    // sequencer: issue reads, wait for the pipe to drain, load the result
    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && i_stall;
        n_out_inside = r_out_inside;
        unique case (r_state)
            S_IDLE: begin
                if (w_test) begin
                    n_n   = w_n_eff;
                    n_cnt = '0;
                    n_state = (w_n_eff == '0) ? S_FINISH : S_READ;
                end
            end
            S_READ: begin
                n_cnt = r_cnt + NW'(1);
                if (r_cnt == r_n) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_stat.done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    // empty polygon is always outside
                    n_out_inside = (r_n != '0) && w_stat.parity;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_cnt       <= '0;
            r_n         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= (r_state == S_READ);
            r_cnt       <= n_cnt;
            r_n         <= n_n;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_test) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        r_rd_prime   <= (r_cnt == '0);
        r_rd_last    <= (r_cnt == r_n);
        r_out_inside <= n_out_inside;
    end

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_out_inside;

    // no vertex reads in flight once the block takes beats again
    `PPT_ASSERT_NOW(a_idle_no_reads, !o_stall, !r_rd_vld, "vertex read in flight while idle")
    // the read counter never runs past the vertex count
    `PPT_ASSERT_NOW(a_cnt_bound, r_state == S_READ, r_cnt <= r_n, "read counter overran")
    // the last edge only drains while the sequencer waits for it
    `PPT_ASSERT_NOW(a_done_in_wait, w_stat.done, r_state == S_WAIT, "edge done outside wait")
    // a result beat appears only out of the finish state
    `PPT_ASSERT_NEXT(a_out_from_finish, !r_out_valid && r_state != S_FINISH, !r_out_valid,
                     "result raised without a finished test")

endmodule

/* dv/testbench.sv */
// self-checking testbench for point_in_polygon_test, the crossing-number geofence
// depends on ppt_pkg and the point_in_polygon_test rtl; needs no files or arguments
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 80;       // full 64-vertex walk plus pipeline, with margin
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 800_000;
    localparam int RANDOM_BEATS = 1200;
    localparam int MAX_PRINTED  = 50;
    localparam int MAX_IDLE     = 11;
    localparam int COORD_MIN    = -(1 << (ppt_pkg::PPT_COORD_WIDTH - 1));
    localparam int COORD_MAX    = (1 << (ppt_pkg::PPT_COORD_WIDTH - 1)) - 1;

    typedef logic signed [ppt_pkg::PPT_COORD_WIDTH-1:0] t_coord;

    // one test point waiting for its answer
    typedef struct {
        t_coord px;
        t_coord py;
        logic   is_in;
    } t_probe;

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_cfg_we       = 1'b0;
    logic [ppt_pkg::COUNT_WIDTH-1:0] i_cfg_wdata    = '0;
    logic                            i_valid        = 1'b0;
    logic                            o_stall;
    logic                            i_command      = ppt_pkg::CMD_WRITE;
    logic [ppt_pkg::INDEX_WIDTH-1:0] i_vertex_index = '0;
    t_coord                          i_coord_x      = '0;
    t_coord                          i_coord_y      = '0;
    logic                            o_valid;
    logic                            i_stall        = 1'b0;
    logic                            o_inside_res;

    // our own copy of the vertex store and the count register
    t_coord poly_x [ppt_pkg::PPT_MAX_VERTICES];
    t_coord poly_y [ppt_pkg::PPT_MAX_VERTICES];
    int     poly_count = 0;

    t_probe pending_inside [$];

    int   error_count  = 0;
    int   beats_sent   = 0;
    int   cycle_count  = 0;
    int   send_gap_max = MAX_IDLE;
    int   stall_max    = MAX_IDLE;
    int   stall_left   = 0;
    logic hold_off     = 1'b0;
    event hold_request;

    // coordinate window that vertices and test points are drawn from
    int box_x_lo = COORD_MIN;
    int box_x_hi = COORD_MAX;
    int box_y_lo = COORD_MIN;
    int box_y_hi = COORD_MAX;

    point_in_polygon_test dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_inside_res   (o_inside_res)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // crossing parity over the edges (i, i-1), wrapping at vertex 0
    // left-of-edge is decided exactly by cross-multiplying in 64 bits
    function automatic logic ray_cast_inside(input t_coord px, input t_coord py);
        int     n, i, j, crossings;
        longint lpx, lpy, xi, yi, xj, yj, dy, lhs, rhs;
        logic   left;
        n = (poly_count > ppt_pkg::PPT_MAX_VERTICES) ? ppt_pkg::PPT_MAX_VERTICES
                                                     : poly_count;
        if (n == 0) begin
            return 1'b0;
        end
        lpx = longint'(px);
        lpy = longint'(py);
        crossings = 0;
        j = n - 1;
        for (i = 0; i < n; i++) begin
            xi = longint'(poly_x[i]);
            yi = longint'(poly_y[i]);
            xj = longint'(poly_x[j]);
            yj = longint'(poly_y[j]);
            // only edges that straddle the ray's y
            if ((yi > lpy) != (yj > lpy)) begin
                dy   = yj - yi;
                lhs  = (lpx - xi) * dy;
                rhs  = (xj - xi) * (lpy - yi);
                left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
                if (left) begin
                    crossings++;
                end
            end
            j = i;
        end
        return crossings[0];
    endfunction

    function automatic t_coord rand_coord(input int lo, input int hi);
        return t_coord'(lo + int'($urandom_range(hi - lo, 0)));
    endfunction

    task automatic flag_mismatch(input string what);
        if (error_count < MAX_PRINTED) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
        error_count++;
    endtask

    // one input beat; valid stays high on return so a back-to-back beat
    // needs no second assignment in the same step
    task automatic send_beat(input logic cmd, input int slot, input int x, input int y);
        int     gap;
        t_probe probe;
        gap = $urandom_range(send_gap_max, 0);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_vertex_index <= slot[ppt_pkg::INDEX_WIDTH-1:0];
        i_coord_x      <= t_coord'(x);
        i_coord_y      <= t_coord'(y);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // beat taken at this edge: update the model in the same order as the block
        if (cmd == ppt_pkg::CMD_WRITE) begin
            poly_x[slot[ppt_pkg::INDEX_WIDTH-1:0]] = t_coord'(x);
            poly_y[slot[ppt_pkg::INDEX_WIDTH-1:0]] = t_coord'(y);
        end else begin
            probe.px    = t_coord'(x);
            probe.py    = t_coord'(y);
            probe.is_in = ray_cast_inside(t_coord'(x), t_coord'(y));
            pending_inside = {pending_inside, probe};
        end
        beats_sent++;
    endtask

    // register write only with nothing in flight and the input quiet
    task automatic write_vertex_count(input int value);
        i_valid <= 1'b0;
        while (pending_inside.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[ppt_pkg::COUNT_WIDTH-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        poly_count  = value & ((1 << ppt_pkg::COUNT_WIDTH) - 1);
    endtask

    task automatic pick_box();
        int cx, cy, half;
        if ($urandom_range(3, 0) == 0) begin
            box_x_lo = COORD_MIN;
            box_x_hi = COORD_MAX;
            box_y_lo = COORD_MIN;
            box_y_hi = COORD_MAX;
        end else begin
            half = 1 << $urandom_range(14, 2);
            cx   = int'(rand_coord(COORD_MIN, COORD_MAX));
            cy   = int'(rand_coord(COORD_MIN, COORD_MAX));
            box_x_lo = (cx - half < COORD_MIN) ? COORD_MIN : cx - half;
            box_x_hi = (cx + half > COORD_MAX) ? COORD_MAX : cx + half;
            box_y_lo = (cy - half < COORD_MIN) ? COORD_MIN : cy - half;
            box_y_hi = (cy + half > COORD_MAX) ? COORD_MAX : cy + half;
        end
    endtask

    // fills slots 0..n-1, with some horizontal and vertical edges
    task automatic write_polygon(input int n);
        int     k;
        t_coord x, y;
        for (k = 0; k < n; k++) begin
            x = rand_coord(box_x_lo, box_x_hi);
            y = rand_coord(box_y_lo, box_y_hi);
            if (k != 0 && $urandom_range(3, 0) == 0) begin
                y = poly_y[k-1];
            end else if (k != 0 && $urandom_range(5, 0) == 0) begin
                x = poly_x[k-1];
            end
            send_beat(ppt_pkg::CMD_WRITE, k, int'(x), int'(y));
        end
    endtask

    // test point in the window, often on a vertex's y (ray through a vertex),
    // on a vertex's x, exactly on a vertex, or anywhere in the plane
    task automatic send_probe();
        int     n, r, k;
        t_coord px, py;
        n  = (poly_count > ppt_pkg::PPT_MAX_VERTICES) ? ppt_pkg::PPT_MAX_VERTICES
                                                      : poly_count;
        px = rand_coord(box_x_lo, box_x_hi);
        py = rand_coord(box_y_lo, box_y_hi);
        r  = $urandom_range(9, 0);
        k  = (n == 0) ? 0 : $urandom_range(n - 1, 0);
        if (n != 0 && r < 3) begin
            py = poly_y[k];
        end else if (n != 0 && r == 3) begin
            px = poly_x[k];
        end else if (n != 0 && r == 4) begin
            px = poly_x[k];
            py = poly_y[k];
        end else if (r == 5) begin
            px = rand_coord(COORD_MIN, COORD_MAX);
            py = rand_coord(COORD_MIN, COORD_MAX);
        end
        // slot is a don't-care on a test beat, so let it toggle
        send_beat(ppt_pkg::CMD_TEST, $urandom_range(ppt_pkg::PPT_MAX_VERTICES - 1, 0),
                  int'(px), int'(py));
    endtask

    task automatic test_empty_polygon();
        write_vertex_count(0);
        send_beat(ppt_pkg::CMD_TEST, '1, COORD_MIN, COORD_MAX);
        send_beat(ppt_pkg::CMD_TEST, '0, COORD_MAX, COORD_MIN);
        send_beat(ppt_pkg::CMD_TEST, '0, 0, 0);
    endtask

    // square on the corners of the coordinate range, points inside and on its sides
    task automatic test_corner_square();
        send_beat(ppt_pkg::CMD_WRITE, 0, COORD_MIN, COORD_MIN);
        send_beat(ppt_pkg::CMD_WRITE, 1, COORD_MAX, COORD_MIN);
        send_beat(ppt_pkg::CMD_WRITE, 2, COORD_MAX, COORD_MAX);
        send_beat(ppt_pkg::CMD_WRITE, 3, COORD_MIN, COORD_MAX);
        write_vertex_count(4);
        send_beat(ppt_pkg::CMD_TEST, '0, 0, 0);
        send_beat(ppt_pkg::CMD_TEST, '0, COORD_MIN, 0);
        send_beat(ppt_pkg::CMD_TEST, '0, COORD_MAX, 0);
        send_beat(ppt_pkg::CMD_TEST, '0, 0, COORD_MIN);
        send_beat(ppt_pkg::CMD_TEST, '0, 0, COORD_MAX);
        send_beat(ppt_pkg::CMD_TEST, '0, -1, -1);
    endtask

    // one and two vertices enclose nothing
    task automatic test_thin_polygons();
        write_vertex_count(1);
        send_beat(ppt_pkg::CMD_TEST, '0, 0, 0);
        send_beat(ppt_pkg::CMD_TEST, '0, COORD_MIN, COORD_MIN);
        write_vertex_count(2);
        send_beat(ppt_pkg::CMD_TEST, '0, 0, 0);
        send_beat(ppt_pkg::CMD_TEST, '0, COORD_MIN, 0);
    endtask

    // every slot written, then counts at and above capacity
    task automatic test_count_saturation();
        box_x_lo = COORD_MIN;
        box_x_hi = COORD_MAX;
        box_y_lo = COORD_MIN;
        box_y_hi = COORD_MAX;
        write_polygon(ppt_pkg::PPT_MAX_VERTICES);
        write_vertex_count(ppt_pkg::PPT_MAX_VERTICES);
        repeat (4) send_probe();
        write_vertex_count((1 << ppt_pkg::COUNT_WIDTH) - 1);
        repeat (4) send_probe();
        write_vertex_count(ppt_pkg::PPT_MAX_VERTICES + 1);
        repeat (2) send_probe();
    endtask

    // receiver holds off while the sender keeps offering beats, so the
    // output register fills, a finished test waits and the input stalls
    task automatic test_output_hold_off();
        int k;
        pick_box();
        write_polygon(5);
        write_vertex_count(5);
        send_gap_max = 0;
        -> hold_request;
        for (k = 0; k < 20; k++) begin
            if (k % 5 == 4) begin
                send_beat(ppt_pkg::CMD_WRITE, 40 + k, int'(rand_coord(box_x_lo, box_x_hi)),
                          int'(rand_coord(box_y_lo, box_y_hi)));
            end else begin
                send_probe();
            end
        end
        send_gap_max = MAX_IDLE;
    endtask

    task automatic test_random_polygons();
        int target, n, r, mode, k;
        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target) begin
            // per phase: no idling, both idle, sender only, receiver only
            mode = $urandom_range(3, 0);
            send_gap_max = (mode == 0 || mode == 3) ? 0 : MAX_IDLE;
            stall_max    = (mode == 0 || mode == 2) ? 0 : MAX_IDLE;
            // mostly small polygons, a few up to capacity
            r = $urandom_range(9, 0);
            if (r == 0) begin
                n = $urandom_range(2, 1);
            end else if (r < 7) begin
                n = $urandom_range(10, 3);
            end else if (r < 9) begin
                n = $urandom_range(32, 11);
            end else begin
                n = $urandom_range(ppt_pkg::PPT_MAX_VERTICES, 33);
            end
            pick_box();
            write_polygon(n);
            // all slots hold data since the saturation test, so any count is safe
            if ($urandom_range(7, 0) == 0) begin
                write_vertex_count($urandom_range((1 << ppt_pkg::COUNT_WIDTH) - 1, 0));
            end else begin
                write_vertex_count(n);
            end
            k = $urandom_range(30, 6);
            repeat (k) begin
                if ($urandom_range(4, 0) == 0) begin
                    send_beat(ppt_pkg::CMD_WRITE,
                              $urandom_range(ppt_pkg::PPT_MAX_VERTICES - 1, 0),
                              int'(rand_coord(box_x_lo, box_x_hi)),
                              int'(rand_coord(box_y_lo, box_y_hi)));
                end else begin
                    send_probe();
                end
            end
        end
        send_gap_max = MAX_IDLE;
        stall_max    = MAX_IDLE;
    endtask

    // result side: check each taken beat, then draw the wait before the next
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_inside.size() == 0) begin
                flag_mismatch($sformatf("result beat inside_res=%0b with no test pending",
                                        o_inside_res));
            end else if (o_inside_res !== pending_inside[0].is_in) begin
                flag_mismatch($sformatf("inside_res %0b, expected %0b for point (%0d, %0d)",
                                        o_inside_res, pending_inside[0].is_in,
                                        pending_inside[0].px, pending_inside[0].py));
                void'(pending_inside.pop_front());
            end else begin
                void'(pending_inside.pop_front());
            end
            stall_left = $urandom_range(stall_max, 0);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_stall <= hold_off || (stall_left != 0);
    end

    // long receiver hold-off, counted here
    initial begin
        forever begin
            @(hold_request);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_polygon();
        test_corner_square();
        test_thin_polygons();
        test_count_saturation();
        test_output_hold_off();
        test_random_polygons();
        i_valid <= 1'b0;
        while (pending_inside.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ppt_pkg.sv
rtl/core/ppt_ram.sv
rtl/core/ppt_edge.sv
rtl/core/point_in_polygon_test.sv
dv/testbench.sv
